[hdl/i2c_register_access_master_assert.svh]
// Assertion macros for the I2C register access master RTL.
`ifndef I2C_REGISTER_ACCESS_MASTER_ASSERT_SVH
`define I2C_REGISTER_ACCESS_MASTER_ASSERT_SVH

// Same-cycle implication, sampled on clk and held off while rst_n is low.
`define I2CRAM_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("i2c register access master check failed");

// Next-cycle implication, sampled on clk and held off while rst_n is low.
`define I2CRAM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("i2c register access master check failed");

`endif

[hdl/i2cram_pkg.sv]
// Types, constants and phase tables of the I2C register access master.
`timescale 1ns / 1ps

package i2cram_pkg;

    localparam int DEV_ADDR_W  = 7;
    localparam int TU_W        = 10;
    localparam int TIMER_W     = 12;
    localparam int ACK_CNT_W   = 10;
    localparam int BIT_CNT_W   = 4;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 10;

    localparam logic [DEV_ADDR_W-1:0] DEV_ADDR_RESET    = 7'h68;
    localparam logic [TU_W-1:0]       TU_RESET          = 10'd50;
    localparam logic [ACK_CNT_W-1:0]  ACK_TIMEOUT_RESET = 10'd250;
    localparam logic [BIT_CNT_W-1:0]  BITS_PER_BYTE     = 4'd8;

    typedef enum logic [4:0] {
        PH_IDLE      = 5'd0,
        PH_START_A   = 5'd1,
        PH_START_B   = 5'd2,
        PH_TX_SETUP  = 5'd3,
        PH_TX_HIGH   = 5'd4,
        PH_TX_HOLD   = 5'd5,
        PH_ACK_SETUP = 5'd6,
        PH_ACK_HIGH  = 5'd7,
        PH_ACK_POLL  = 5'd8,
        PH_RX_LOW    = 5'd9,
        PH_RX_HIGH   = 5'd10,
        PH_NACK_LOW  = 5'd11,
        PH_NACK_HIGH = 5'd12,
        PH_STOP_A    = 5'd13,
        PH_STOP_B    = 5'd14
    } phase_t;

    typedef enum logic [1:0] {
        ACT_NONE  = 2'd0,
        ACT_WRITE = 2'd1,
        ACT_READ  = 2'd2
    } action_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_DEVICE_ADDRESS = 2'd0,
        CFG_TIME_UNIT      = 2'd1,
        CFG_ACK_TIMEOUT    = 2'd2
    } cfg_index_t;

    typedef enum logic [2:0] {
        STEP_DEV_ADDR = 3'd0,
        STEP_REG_ADDR = 3'd1,
        STEP_DATA     = 3'd2,
        STEP_RX       = 3'd3
    } byte_step_t;

    typedef enum logic [1:0] {
        PULL_RELEASE = 2'd0,
        PULL_LOW     = 2'd1,
        PULL_DATA    = 2'd2
    } pull_t;

    typedef struct packed {
        logic [DEV_ADDR_W-1:0] device_address;
        logic [TU_W-1:0]       time_unit;
        logic [ACK_CNT_W-1:0]  ack_timeout;
    } cfg_t;

    typedef struct packed {
        logic [1:0] action;
        logic [7:0] reg_address;
        logic [7:0] write_data;
        logic       sda_in;
    } item_t;

    typedef struct packed {
        logic       scl_level;
        logic       sda_pull_low;
        logic       busy;
        logic       done;
        logic [7:0] read_data;
        logic       ack_error;
    } result_t;

    function automatic logic phase_scl(input phase_t p);
        logic r;
        case (p) inside
            PH_IDLE, PH_START_A, PH_START_B, PH_TX_HIGH, PH_ACK_HIGH, PH_ACK_POLL,
            PH_RX_HIGH, PH_NACK_HIGH, PH_STOP_B: r = 1'b1;
            default:                               r = 1'b0;
        endcase
        return r;
    endfunction

    function automatic pull_t phase_pull(input phase_t p);
        pull_t r;
        case (p) inside
            PH_START_B, PH_STOP_A, PH_STOP_B:    r = PULL_LOW;
            PH_TX_SETUP, PH_TX_HIGH, PH_TX_HOLD: r = PULL_DATA;
            default:                             r = PULL_RELEASE;
        endcase
        return r;
    endfunction

    // Length of each timed phase in time units.
    function automatic logic [2:0] phase_units(input phase_t p);
        logic [2:0] r;
        case (p) inside
            PH_START_A, PH_START_B, PH_STOP_A, PH_STOP_B:          r = 3'd4;
            PH_TX_SETUP, PH_TX_HIGH, PH_TX_HOLD, PH_RX_LOW,
            PH_NACK_LOW, PH_NACK_HIGH:                             r = 3'd2;
            PH_ACK_SETUP, PH_ACK_HIGH, PH_RX_HIGH:                 r = 3'd1;
            default:                                               r = 3'd0;
        endcase
        return r;
    endfunction

endpackage

[hdl/i2cram_cfg.sv]
// Configuration registers of the I2C register access master.
`timescale 1ns / 1ps

module i2cram_cfg
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [i2cram_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [i2cram_pkg::CFG_DATA_W-1:0]  cfg_data,
    output i2cram_pkg::cfg_t                   cfg
);

    i2cram_pkg::cfg_t cfg_reg;

    // Every register takes its word as soon as it is offered, so the port never holds off.
    assign cfg_ready = 1'b1;
    assign cfg      = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.device_address <= i2cram_pkg::DEV_ADDR_RESET;
            cfg_reg.time_unit      <= i2cram_pkg::TU_RESET;
            cfg_reg.ack_timeout    <= i2cram_pkg::ACK_TIMEOUT_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                i2cram_pkg::CFG_DEVICE_ADDRESS:
                    cfg_reg.device_address <= cfg_data[i2cram_pkg::DEV_ADDR_W-1:0];
                i2cram_pkg::CFG_TIME_UNIT:
                    cfg_reg.time_unit <= cfg_data[i2cram_pkg::TU_W-1:0];
                i2cram_pkg::CFG_ACK_TIMEOUT:
                    cfg_reg.ack_timeout <= cfg_data[i2cram_pkg::ACK_CNT_W-1:0];
                default:
                    cfg_reg <= cfg_reg;
            endcase
        end
    end

endmodule

[hdl/i2cram_core.sv]
// Bus sequencer state and its one-step update for the I2C register access master.
`timescale 1ns / 1ps

module i2cram_core
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step_en,
    input  i2cram_pkg::item_t   item,
    input  i2cram_pkg::cfg_t    cfg,
    output i2cram_pkg::result_t res
);

    i2cram_pkg::phase_t                      phase_reg, phase_next;
    logic [i2cram_pkg::TIMER_W-1:0]          delay_reg, delay_next;
    logic [i2cram_pkg::BIT_CNT_W-1:0]        bit_cnt_reg, bit_cnt_next;
    logic [7:0]                              shift_reg, shift_next;
    logic [i2cram_pkg::ACK_CNT_W-1:0]        ack_cnt_reg, ack_cnt_next;
    i2cram_pkg::byte_step_t                  step_reg, step_next;
    logic                                    is_read_reg, is_read_next;
    logic [7:0]                              held_reg_addr_reg, held_reg_addr_next;
    logic [7:0]                              held_wdata_reg, held_wdata_next;
    logic                                    error_reg, error_next;

    logic [i2cram_pkg::TU_W-1:0]             tu;
    logic [i2cram_pkg::TIMER_W-1:0]          limit;
    logic [i2cram_pkg::TIMER_W:0]            delay_inc;
    logic                                    done;
    i2cram_pkg::pull_t                       pull;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= i2cram_pkg::PH_IDLE;
            delay_reg         <= '0;
            bit_cnt_reg       <= '0;
            shift_reg         <= '0;
            ack_cnt_reg       <= '0;
            step_reg          <= i2cram_pkg::STEP_DEV_ADDR;
            is_read_reg       <= 1'b0;
            held_reg_addr_reg <= '0;
            held_wdata_reg    <= '0;
            error_reg         <= 1'b0;
        end
        else if (step_en)
        begin
            phase_reg         <= phase_next;
            delay_reg         <= delay_next;
            bit_cnt_reg       <= bit_cnt_next;
            shift_reg         <= shift_next;
            ack_cnt_reg       <= ack_cnt_next;
            step_reg          <= step_next;
            is_read_reg       <= is_read_next;
            held_reg_addr_reg <= held_reg_addr_next;
            held_wdata_reg    <= held_wdata_next;
            error_reg         <= error_next;
        end
    end

    // Phase length limit: units are 1, 2 or 4, so it is a shift of the time unit.
    always_comb
    begin
        tu = (cfg.time_unit == '0) ? i2cram_pkg::TU_W'(1) : cfg.time_unit;
        case (i2cram_pkg::phase_units(phase_reg))
            3'd1:    limit = {2'b00, tu};
            3'd2:    limit = {1'b0, tu, 1'b0};
            3'd4:    limit = {tu, 2'b00};
            default: limit = '0;
        endcase
        delay_inc = {1'b0, delay_reg} + 13'd1;
    end

    always_comb
    begin
        phase_next         = phase_reg;
        delay_next         = delay_reg;
        bit_cnt_next       = bit_cnt_reg;
        shift_next         = shift_reg;
        ack_cnt_next       = ack_cnt_reg;
        step_next          = step_reg;
        is_read_next       = is_read_reg;
        held_reg_addr_next = held_reg_addr_reg;
        held_wdata_next    = held_wdata_reg;
        error_next         = error_reg;
        done               = 1'b0;

        case (phase_reg)
            i2cram_pkg::PH_IDLE:
            begin
                if (item.action == i2cram_pkg::ACT_WRITE || item.action == i2cram_pkg::ACT_READ)
                begin
                    is_read_next       = (item.action == i2cram_pkg::ACT_READ);
                    held_reg_addr_next = item.reg_address;
                    held_wdata_next    = item.write_data;
                    step_next          = i2cram_pkg::STEP_DEV_ADDR;
                    error_next         = 1'b0;
                    phase_next         = i2cram_pkg::PH_START_A;
                    delay_next         = '0;
                end
            end

            i2cram_pkg::PH_ACK_POLL:
            begin
                if (!item.sda_in)
                begin
                    // Acknowledged: pick the next byte of the transaction.
                    delay_next = '0;
                    case (step_reg)
                        i2cram_pkg::STEP_DEV_ADDR:
                        begin
                            step_next    = i2cram_pkg::STEP_REG_ADDR;
                            shift_next   = held_reg_addr_reg;
                            bit_cnt_next = '0;
                            phase_next   = i2cram_pkg::PH_TX_SETUP;
                        end
                        i2cram_pkg::STEP_REG_ADDR:
                        begin
                            step_next = i2cram_pkg::STEP_DATA;
                            if (is_read_reg)
                            begin
                                phase_next = i2cram_pkg::PH_START_A;
                            end
                            else
                            begin
                                shift_next   = held_wdata_reg;
                                bit_cnt_next = '0;
                                phase_next   = i2cram_pkg::PH_TX_SETUP;
                            end
                        end
                        i2cram_pkg::STEP_DATA:
                        begin
                            if (is_read_reg)
                            begin
                                step_next    = i2cram_pkg::STEP_RX;
                                shift_next   = '0;
                                bit_cnt_next = '0;
                                phase_next   = i2cram_pkg::PH_RX_LOW;
                            end
                            else
                            begin
                                phase_next = i2cram_pkg::PH_STOP_A;
                            end
                        end
                        default:
                            phase_next = i2cram_pkg::PH_STOP_A;
                    endcase
                end
                else if (ack_cnt_reg >= cfg.ack_timeout)
                begin
                    error_next = 1'b1;
                    phase_next = i2cram_pkg::PH_STOP_A;
                    delay_next = '0;
                end
                else
                begin
                    ack_cnt_next = ack_cnt_reg + 1'b1;
                end
            end

            i2cram_pkg::PH_START_A, i2cram_pkg::PH_START_B, i2cram_pkg::PH_TX_SETUP,
            i2cram_pkg::PH_TX_HIGH, i2cram_pkg::PH_TX_HOLD, i2cram_pkg::PH_ACK_SETUP,
            i2cram_pkg::PH_ACK_HIGH, i2cram_pkg::PH_RX_LOW, i2cram_pkg::PH_RX_HIGH,
            i2cram_pkg::PH_NACK_LOW, i2cram_pkg::PH_NACK_HIGH, i2cram_pkg::PH_STOP_A,
            i2cram_pkg::PH_STOP_B:
            begin
                // A read bit is taken on the first cycle of the SCL high phase.
                if (phase_reg == i2cram_pkg::PH_RX_HIGH && delay_reg == '0)
                begin
                    shift_next = {shift_reg[6:0], item.sda_in};
                end

                if (delay_inc >= {1'b0, limit})
                begin
                    delay_next = '0;
                    case (phase_reg)
                        i2cram_pkg::PH_START_A:   phase_next = i2cram_pkg::PH_START_B;
                        i2cram_pkg::PH_START_B:
                        begin
                            shift_next   = {cfg.device_address,
                                            step_reg == i2cram_pkg::STEP_DATA};
                            bit_cnt_next = '0;
                            phase_next   = i2cram_pkg::PH_TX_SETUP;
                        end
                        i2cram_pkg::PH_TX_SETUP:  phase_next = i2cram_pkg::PH_TX_HIGH;
                        i2cram_pkg::PH_TX_HIGH:   phase_next = i2cram_pkg::PH_TX_HOLD;
                        i2cram_pkg::PH_TX_HOLD:
                        begin
                            shift_next   = {shift_reg[6:0], 1'b0};
                            bit_cnt_next = bit_cnt_reg + 1'b1;
                            phase_next   = (bit_cnt_next >= i2cram_pkg::BITS_PER_BYTE) ?
                                           i2cram_pkg::PH_ACK_SETUP : i2cram_pkg::PH_TX_SETUP;
                        end
                        i2cram_pkg::PH_ACK_SETUP: phase_next = i2cram_pkg::PH_ACK_HIGH;
                        i2cram_pkg::PH_ACK_HIGH:
                        begin
                            ack_cnt_next = '0;
                            phase_next   = i2cram_pkg::PH_ACK_POLL;
                        end
                        i2cram_pkg::PH_RX_LOW:    phase_next = i2cram_pkg::PH_RX_HIGH;
                        i2cram_pkg::PH_RX_HIGH:
                        begin
                            bit_cnt_next = bit_cnt_reg + 1'b1;
                            phase_next   = (bit_cnt_next >= i2cram_pkg::BITS_PER_BYTE) ?
                                           i2cram_pkg::PH_NACK_LOW : i2cram_pkg::PH_RX_LOW;
                        end
                        i2cram_pkg::PH_NACK_LOW:  phase_next = i2cram_pkg::PH_NACK_HIGH;
                        i2cram_pkg::PH_NACK_HIGH: phase_next = i2cram_pkg::PH_STOP_A;
                        i2cram_pkg::PH_STOP_A:    phase_next = i2cram_pkg::PH_STOP_B;
                        i2cram_pkg::PH_STOP_B:
                        begin
                            phase_next = i2cram_pkg::PH_IDLE;
                            done       = 1'b1;
                        end
                        default:                  phase_next = i2cram_pkg::PH_IDLE;
                    endcase
                end
                else
                begin
                    delay_next = delay_reg + 1'b1;
                end
            end

            default:
            begin
                phase_next = i2cram_pkg::PH_IDLE;
                delay_next = '0;
            end
        endcase
    end

    // Bus levels follow the phase being entered and the MSB of the updated shifter.
    always_comb
    begin
        pull              = i2cram_pkg::phase_pull(phase_next);
        res.scl_level     = i2cram_pkg::phase_scl(phase_next);
        res.sda_pull_low  = (pull == i2cram_pkg::PULL_DATA) ? ~shift_next[7] :
                            (pull == i2cram_pkg::PULL_LOW);
        res.busy          = (phase_next != i2cram_pkg::PH_IDLE);
        res.done          = done;
        res.read_data     = (done && is_read_next && !error_next) ? shift_next : 8'h00;
        res.ack_error     = done && error_next;
    end

endmodule

[hdl/i2c_register_access_master.sv]
// Top level of the I2C register access master: input word register, sequencer, result register.
// An accepted word waits in the input register, then its result is registered onto out_valid.
// One word per cycle unless out_stall holds off; the sequencer steps once per accepted word.
// The only backpressure is out_stall, held back through the input register and in_stall.
// Reset (rst_n low, asynchronous) empties both registers, idles the bus, loads default config.
`timescale 1ns / 1ps
`include "i2c_register_access_master_assert.svh"

module i2c_register_access_master
(
    input  logic                               clk,
    input  logic                               rst_n,

    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [1:0]                         action,
    input  logic [7:0]                         reg_address,
    input  logic [7:0]                         write_data,
    input  logic                               sda_in,

    output logic                               out_valid,
    input  logic                               out_stall,
    output logic                               scl_level,
    output logic                               sda_pull_low,
    output logic                               busy_res,
    output logic                               done_res,
    output logic [7:0]                         read_data,
    output logic                               ack_error,

    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [i2cram_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [i2cram_pkg::CFG_DATA_W-1:0]  cfg_data
);

    i2cram_pkg::cfg_t    cfg;
    i2cram_pkg::item_t   item_reg;
    logic                item_valid_reg;
    i2cram_pkg::result_t res;
    i2cram_pkg::result_t out_reg;
    logic                out_valid_reg;
    logic                advance;
    logic                in_take;

    // The held word moves on whenever the result register is empty or being drained.
    assign advance  = item_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = item_valid_reg && !advance;
    assign in_take  = in_valid && !in_stall;

    i2cram_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    i2cram_core u_core
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .step_en (advance),
        .item    (item_reg),
        .cfg     (cfg),
        .res     (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (in_take)
            begin
                item_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                item_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            item_reg.action      <= action;
            item_reg.reg_address <= reg_address;
            item_reg.write_data  <= write_data;
            item_reg.sda_in      <= sda_in;
        end
        if (advance)
        begin
            out_reg <= res;
        end
    end

    assign out_valid    = out_valid_reg;
    assign scl_level    = out_reg.scl_level;
    assign sda_pull_low = out_reg.sda_pull_low;
    assign busy_res     = out_reg.busy;
    assign done_res     = out_reg.done;
    assign read_data    = out_reg.read_data;
    assign ack_error    = out_reg.ack_error;

    `I2CRAM_ASSERT_NOW(a_done_ends_busy, out_valid_reg && out_reg.done, !out_reg.busy)
    `I2CRAM_ASSERT_NOW(a_error_only_with_done, out_valid_reg && out_reg.ack_error, out_reg.done)
    `I2CRAM_ASSERT_NOW(a_data_only_with_done, out_valid_reg && (|out_reg.read_data), out_reg.done)
    `I2CRAM_ASSERT_NEXT(a_advance_fills_result, advance, out_valid_reg)

endmodule

[tb/sv/tb_i2c_register_access_master.sv]
// Self-checking bench for the I2C register access master: random bus words against a cycle model.
`timescale 1ns / 1ps

module tb_i2c_register_access_master;
    import i2cram_pkg::*;

    localparam logic [1:0] ACT_UNUSED  = 2'd3;
    localparam int         QUIET_LIMIT = 4000;
    localparam int         HOLD_LEN    = 300;

    typedef struct packed {
        phase_t      phase;
        logic [11:0] timer;
        logic [3:0]  bits;
        logic [7:0]  shreg;
        logic [9:0]  ack_cnt;
        byte_step_t  step;
        logic        rd;
        logic [7:0]  reg_addr;
        logic [7:0]  wdata;
        logic        err;
        logic        scl;
        logic        sda;
    } bus_state_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    logic [1:0] action = ACT_NONE;
    logic [7:0] reg_address = 8'h00;
    logic [7:0] write_data = 8'h00;
    logic       sda_in = 1'b0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic       scl_level;
    logic       sda_pull_low;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_data;
    logic       ack_error;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = CFG_DEVICE_ADDRESS;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    item_t      tick_q[$];
    result_t    expected_pins_q[$];
    cfg_t       bus_cfg;
    bus_state_t stim_state;
    bus_state_t pins_state;
    bit         stim_nack = 1'b0;
    int         n_issued = 0;
    int         n_checked = 0;
    int         n_fail = 0;
    int         src_gap_max = 16;
    int         snk_gap_max = 16;
    int         src_w = 0;
    int         snk_w = 0;
    int         quiet_cycles = 0;
    int         hold_cnt = 0;
    logic       hold_go = 1'b0;
    logic       long_hold;
    item_t      drv_word;
    result_t    seen;
    result_t    want;

    i2c_register_access_master uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .action       (action),
        .reg_address  (reg_address),
        .write_data   (write_data),
        .sda_in       (sda_in),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .scl_level    (scl_level),
        .sda_pull_low (sda_pull_low),
        .busy_res     (busy_res),
        .done_res     (done_res),
        .read_data    (read_data),
        .ack_error    (ack_error),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    function automatic bus_state_t bus_idle();
        bus_state_t s;
        s = '0;
        s.phase = PH_IDLE;
        s.step = STEP_DEV_ADDR;
        s.scl = 1'b1;
        return s;
    endfunction

    function automatic int unsigned phase_len(input phase_t p);
        case (p)
            PH_START_A, PH_START_B, PH_STOP_A, PH_STOP_B: return 4;
            PH_TX_SETUP, PH_TX_HIGH, PH_TX_HOLD, PH_RX_LOW, PH_NACK_LOW, PH_NACK_HIGH: return 2;
            PH_ACK_SETUP, PH_ACK_HIGH, PH_RX_HIGH: return 1;
            default: return 0;
        endcase
    endfunction

    // Entering a phase restarts its timer and sets both bus lines.
    function automatic void bus_enter(inout bus_state_t s, input phase_t p);
        s.phase = p;
        s.timer = '0;
        case (p)
            PH_IDLE, PH_START_A, PH_START_B, PH_TX_HIGH, PH_ACK_HIGH, PH_ACK_POLL,
            PH_RX_HIGH, PH_NACK_HIGH, PH_STOP_B: s.scl = 1'b1;
            default: s.scl = 1'b0;
        endcase
        case (p)
            PH_START_B, PH_STOP_A, PH_STOP_B:    s.sda = 1'b1;
            PH_TX_SETUP, PH_TX_HIGH, PH_TX_HOLD: s.sda = ~s.shreg[7];
            default:                             s.sda = 1'b0;
        endcase
    endfunction

    function automatic void bus_send(inout bus_state_t s, input logic [7:0] b);
        s.shreg = b;
        s.bits = '0;
        bus_enter(s, PH_TX_SETUP);
    endfunction

    function automatic void bus_after_ack(inout bus_state_t s);
        case (s.step)
            STEP_DEV_ADDR:
            begin
                s.step = STEP_REG_ADDR;
                bus_send(s, s.reg_addr);
            end
            STEP_REG_ADDR:
            begin
                s.step = STEP_DATA;
                if (s.rd)
                    bus_enter(s, PH_START_A);
                else
                    bus_send(s, s.wdata);
            end
            STEP_DATA:
            begin
                if (s.rd)
                begin
                    s.step = STEP_RX;
                    s.shreg = '0;
                    s.bits = '0;
                    bus_enter(s, PH_RX_LOW);
                end
                else
                    bus_enter(s, PH_STOP_A);
            end
            default: bus_enter(s, PH_STOP_A);
        endcase
    endfunction

    // Moves on from a timed phase; returns 1 when the transaction has just ended.
    function automatic logic bus_phase_end(inout bus_state_t s, input cfg_t c);
        case (s.phase)
            PH_START_A:   bus_enter(s, PH_START_B);
            PH_START_B:   bus_send(s, {c.device_address, s.step == STEP_DATA});
            PH_TX_SETUP:  bus_enter(s, PH_TX_HIGH);
            PH_TX_HIGH:   bus_enter(s, PH_TX_HOLD);
            PH_TX_HOLD:
            begin
                s.shreg = {s.shreg[6:0], 1'b0};
                s.bits = s.bits + 4'd1;
                bus_enter(s, (s.bits >= 4'd8) ? PH_ACK_SETUP : PH_TX_SETUP);
            end
            PH_ACK_SETUP: bus_enter(s, PH_ACK_HIGH);
            PH_ACK_HIGH:
            begin
                s.ack_cnt = '0;
                bus_enter(s, PH_ACK_POLL);
            end
            PH_RX_LOW:    bus_enter(s, PH_RX_HIGH);
            PH_RX_HIGH:
            begin
                s.bits = s.bits + 4'd1;
                bus_enter(s, (s.bits >= 4'd8) ? PH_NACK_LOW : PH_RX_LOW);
            end
            PH_NACK_LOW:  bus_enter(s, PH_NACK_HIGH);
            PH_NACK_HIGH: bus_enter(s, PH_STOP_A);
            PH_STOP_A:    bus_enter(s, PH_STOP_B);
            PH_STOP_B:
            begin
                bus_enter(s, PH_IDLE);
                return 1'b1;
            end
            default:      bus_enter(s, PH_IDLE);
        endcase
        return 1'b0;
    endfunction

    // One clock of the sequencer for one input word; returns the pin and status word.
    function automatic result_t seq_advance(inout bus_state_t s, input cfg_t c, input item_t w);
        int unsigned tu;
        logic        fin;
        result_t     r;
        tu = (c.time_unit == '0) ? 1 : c.time_unit;
        fin = 1'b0;
        if (s.phase == PH_IDLE)
        begin
            if (w.action == ACT_WRITE || w.action == ACT_READ)
            begin
                s.rd = (w.action == ACT_READ);
                s.reg_addr = w.reg_address;
                s.wdata = w.write_data;
                s.step = STEP_DEV_ADDR;
                s.err = 1'b0;
                bus_enter(s, PH_START_A);
            end
        end
        else if (s.phase == PH_ACK_POLL)
        begin
            if (!w.sda_in)
                bus_after_ack(s);
            else if (s.ack_cnt >= c.ack_timeout)
            begin
                s.err = 1'b1;
                bus_enter(s, PH_STOP_A);
            end
            else
                s.ack_cnt = s.ack_cnt + 10'd1;
        end
        else
        begin
            // A read bit is taken only on the first cycle of the high half.
            if (s.phase == PH_RX_HIGH && s.timer == '0)
                s.shreg = {s.shreg[6:0], w.sda_in};
            if (s.timer + 1 >= phase_len(s.phase) * tu)
                fin = bus_phase_end(s, c);
            else
                s.timer = s.timer + 12'd1;
        end
        r.scl_level = s.scl;
        r.sda_pull_low = s.sda;
        r.busy = (s.phase != PH_IDLE);
        r.done = fin;
        r.read_data = (fin && s.rd && !s.err) ? s.shreg : 8'h00;
        r.ack_error = fin && s.err;
        return r;
    endfunction

    task automatic queue_one(input item_t w);
        void'(seq_advance(stim_state, bus_cfg, w));
        tick_q.push_back(w);
        n_issued++;
    endtask

    // Mostly complete transactions; ACK slots are sampled high one time in four at random and
    // otherwise low, unless the transaction is picked to time out.
    task automatic queue_random(input int count, input int fail_pct, input bit to_idle);
        item_t w;
        int    k;
        k = 0;
        while (k < count || (to_idle && stim_state.phase != PH_IDLE))
        begin
            w.action = 2'($urandom_range(0, 3));
            w.reg_address = 8'($urandom_range(0, 255));
            w.write_data = 8'($urandom_range(0, 255));
            w.sda_in = 1'($urandom_range(0, 1));
            if (stim_state.phase == PH_IDLE)
            begin
                if ($urandom_range(0, 7) == 0)
                    w.action = $urandom_range(0, 1) ? ACT_NONE : ACT_UNUSED;
                else
                    w.action = $urandom_range(0, 1) ? ACT_READ : ACT_WRITE;
                stim_nack = ($urandom_range(0, 99) < fail_pct);
            end
            else if (stim_state.phase == PH_ACK_POLL)
                w.sda_in = stim_nack || ($urandom_range(0, 3) == 0);
            queue_one(w);
            k++;
        end
    endtask

    // Leaves cfg_valid high; the caller lowers it after the last register.
    task automatic write_reg(input cfg_index_t idx, input logic [9:0] val);
        cfg_index <= idx;
        cfg_data <= val;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!(cfg_valid && cfg_ready));
        case (idx)
            CFG_DEVICE_ADDRESS: bus_cfg.device_address = val[6:0];
            CFG_TIME_UNIT:      bus_cfg.time_unit = val;
            CFG_ACK_TIMEOUT:    bus_cfg.ack_timeout = val;
            default:            ;
        endcase
    endtask

    task automatic set_config(input logic [6:0] dev, input logic [9:0] tu, input logic [9:0] tmo,
                              input int src_gap, input int snk_gap);
        while (n_checked < n_issued)
            @(posedge clk);
        write_reg(CFG_DEVICE_ADDRESS, {3'b000, dev});
        write_reg(CFG_TIME_UNIT, tu);
        write_reg(CFG_ACK_TIMEOUT, tmo);
        cfg_valid <= 1'b0;
        src_gap_max = src_gap;
        snk_gap_max = snk_gap;
    endtask

    // Sender: one word per handshake, a random gap drawn after each accepted word.
    always @(posedge clk)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else
        begin
            if (in_valid && !in_stall)
            begin
                drv_word = {action, reg_address, write_data, sda_in};
                want = seq_advance(pins_state, bus_cfg, drv_word);
                expected_pins_q.push_back(want);
                src_w = $urandom_range(0, src_gap_max);
            end
            else if (!in_valid && src_w > 0)
                src_w = src_w - 1;
            if (!(in_valid && in_stall))
            begin
                if (src_w == 0 && tick_q.size() != 0)
                begin
                    drv_word = tick_q.pop_front();
                    action <= drv_word.action;
                    reg_address <= drv_word.reg_address;
                    write_data <= drv_word.write_data;
                    sda_in <= drv_word.sda_in;
                    in_valid <= 1'b1;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // One long receiver hold-off while the sender keeps offering words.
    always @(posedge clk)
    begin
        if (!rst_n)
            hold_cnt <= 0;
        else if (hold_go && hold_cnt < HOLD_LEN)
            hold_cnt <= hold_cnt + 1;
    end

    assign long_hold = hold_go && (hold_cnt < HOLD_LEN);

    // Receiver: checks each accepted word against the oldest expectation.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            snk_w = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                seen = {scl_level, sda_pull_low, busy_res, done_res, read_data, ack_error};
                n_checked <= n_checked + 1;
                if (expected_pins_q.size() == 0)
                begin
                    if (n_fail < 10)
                        $display("word %0d arrived with nothing expected", n_checked);
                    n_fail++;
                end
                else
                begin
                    want = expected_pins_q.pop_front();
                    if (seen.scl_level !== want.scl_level
                        || seen.sda_pull_low !== want.sda_pull_low
                        || seen.busy !== want.busy
                        || seen.done !== want.done
                        || seen.read_data !== want.read_data
                        || seen.ack_error !== want.ack_error)
                    begin
                        if (n_fail < 10)
                        begin
                            $display("mismatch on word %0d (expected/actual): %s%b/%b %s%b/%b",
                                     n_checked, "scl ", want.scl_level, seen.scl_level,
                                     "sda_low ", want.sda_pull_low, seen.sda_pull_low);
                            $display("    busy %b/%b done %b/%b data %h/%h ack_error %b/%b",
                                     want.busy, seen.busy, want.done, seen.done,
                                     want.read_data, seen.read_data,
                                     want.ack_error, seen.ack_error);
                        end
                        n_fail++;
                    end
                end
                snk_w = $urandom_range(0, snk_gap_max);
            end
            else if (snk_w > 0)
                snk_w = snk_w - 1;
            out_stall <= long_hold || (snk_w > 0);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
            || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("watchdog: no handshake for %0d cycles", quiet_cycles);
            $display("== FAIL ==");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        bus_cfg = {DEV_ADDR_RESET, TU_RESET, ACK_TIMEOUT_RESET};
        stim_state = bus_idle();
        pins_state = bus_idle();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Fastest timing and a timeout of one, directed words first.
        set_config(7'h00, 10'd1, 10'd1, 16, 16);
        queue_one('{ACT_NONE,   8'h00, 8'h00, 1'b0});
        queue_one('{ACT_UNUSED, 8'hFF, 8'hFF, 1'b1});
        queue_one('{ACT_NONE,   8'hFF, 8'hFF, 1'b1});
        queue_one('{ACT_WRITE,  8'hFF, 8'h00, 1'b0});
        // Requests while a transaction runs are dropped.
        queue_one('{ACT_READ,   8'h00, 8'hFF, 1'b1});
        queue_one('{ACT_WRITE,  8'hAA, 8'h55, 1'b0});
        queue_one('{ACT_UNUSED, 8'h55, 8'hAA, 1'b1});
        queue_one('{ACT_NONE,   8'h00, 8'hFF, 1'b0});
        queue_random(250, 15, 1'b1);

        // A time unit of zero counts as one; a timeout of zero fails on the first high sample.
        set_config(7'h7F, 10'd0, 10'd0, 0, 0);
        queue_random(200, 10, 1'b1);

        set_config(7'($urandom_range(0, 127)), 10'd2, 10'd3, 0, 16);
        hold_go <= 1'b1;
        queue_random(200, 10, 1'b1);

        set_config(7'($urandom_range(0, 127)), 10'd1, 10'd1023, 16, 0);
        queue_random(200, 5, 1'b1);

        set_config(7'($urandom_range(0, 127)), 10'd3, 10'd2, 16, 16);
        queue_random(150, 20, 1'b1);

        // Slowest timing: only the opening of a transaction fits.
        set_config(DEV_ADDR_RESET, 10'd1023, ACK_TIMEOUT_RESET, 16, 16);
        queue_random(150, 10, 1'b0);

        while (n_checked < n_issued)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (n_fail == 0 && expected_pins_q.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

[i2c_register_access_master.f]
+incdir+hdl
hdl/i2cram_pkg.sv
hdl/i2cram_cfg.sv
hdl/i2cram_core.sv
hdl/i2c_register_access_master.sv
tb/sv/tb_i2c_register_access_master.sv
